// ===== design/acwa_pkg.sv =====
// acwa_pkg: types and constants for the address cache with aging
// no dependencies
package acwa_pkg;

  localparam int unsigned Depth = 32;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = 6;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_LOOKUP_SA = 2'd1,
    MODE_LOOKUP_UID = 2'd2,
    MODE_TICK = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_FULL = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EVICTED = 3'd3,
    ST_TICK_DONE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CFG_WIFI = 3'd0,
    CFG_BLE = 3'd1,
    CFG_LOWPAN = 3'd2,
    CFG_LOCAL_UID = 3'd3,
    CFG_LOCAL_SA = 3'd4,
    CFG_LOCAL_NID = 3'd5
  } cfg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_WRITE,
    FSM_RESULT,
    FSM_OUT
  } fsm_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  media_kind;
    logic [63:0] node_unique_id;
    logic [15:0] node_short_addr;
    logic [15:0] node_net_id;
    logic [15:0] parent_short_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [63:0]     found_unique_id;
    logic [15:0]     found_short_addr;
    logic [15:0]     found_net_id;
    logic [15:0]     found_parent_addr;
    logic [1:0]      found_media;
    logic [CntW-1:0] entry_count;
    logic            last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] unique_id;
    logic [15:0] nwk_addr;
    logic [15:0] net_id;
    logic [15:0] parent_addr;
    logic [1:0]  media;
    logic [7:0]  age;
  } entry_t;

endpackage

// ===== design/acwa_if.sv =====
// acwa_req_if / acwa_rsp_if: valid/ready channels
// depends on acwa_pkg
interface acwa_req_if;
  logic              valid;
  logic              ready;
  acwa_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acwa_rsp_if;
  logic              valid;
  logic              ready;
  acwa_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/address_cache_with_aging.sv =====
// address_cache_with_aging: top level, control sequencer and config registers
// depends on acwa_pkg, acwa_if, acwa_ram
//
//  channel  | dir | transfer when
//  req      | in  | req.valid & req.ready
//  rsp      | out | rsp.valid & rsp.ready
//  cfg      | in  | cfg_we_i
//
// every item scans all slots, one read a cycle while the scan is not stalled;
// an update adds a write state after the scan, and a new request is taken only in idle
// a tick scans twice (age pass, then eviction report); the report pass stalls on rsp.ready
// the single read port of the entry store sets the rate
// reset clears valid bits, count and control; the store itself is not cleared
// a result waits in the output register while rsp.ready is low; the sequencer holds
module address_cache_with_aging (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  acwa_req_if.sink                      req,
  acwa_rsp_if.source                    rsp,
  input  logic                          cfg_we_i,
  input  logic [acwa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [63:0]                   cfg_data_i
);
  localparam int unsigned IW = acwa_pkg::IdxW;
  localparam int unsigned CW = acwa_pkg::CntW;

  // configuration registers
  logic [7:0]  wifi_q, ble_q, lowpan_q;
  logic [63:0] luid_q;
  logic [15:0] lsa_q, lnid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wifi_q <= 8'd3;
      ble_q <= 8'd3;
      lowpan_q <= 8'd3;
      luid_q <= '0;
      lsa_q <= 16'hFFFF;
      lnid_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        acwa_pkg::CFG_WIFI:      wifi_q <= cfg_data_i[7:0];
        acwa_pkg::CFG_BLE:       ble_q <= cfg_data_i[7:0];
        acwa_pkg::CFG_LOWPAN:    lowpan_q <= cfg_data_i[7:0];
        acwa_pkg::CFG_LOCAL_UID: luid_q <= cfg_data_i;
        acwa_pkg::CFG_LOCAL_SA:  lsa_q <= cfg_data_i[15:0];
        acwa_pkg::CFG_LOCAL_NID: lnid_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // state
  acwa_pkg::fsm_e   state_q, state_d;
  acwa_pkg::req_t   req_q;
  logic [acwa_pkg::Depth-1:0] valid_q;
  logic [acwa_pkg::Depth-1:0] evict_q; // slots dropped by the current tick
  logic [CW-1:0]    count_q;
  logic [IW:0]      ptr_q;      // issue pointer, one past end means done
  logic             rd_pend_q;  // read data for rd_idx_q arrives this cycle
  logic [IW-1:0]    rd_idx_q;
  logic             hit_q;
  logic [IW-1:0]    hit_idx_q;
  logic             free_q;
  logic [IW-1:0]    free_idx_q;
  logic             report_q;   // second tick pass: reporting evictions
  acwa_pkg::entry_t hit_ent_q;
  acwa_pkg::rsp_t   out_q;
  logic             out_vld_q;

  // memory ports
  logic             we;
  logic [IW-1:0]    waddr;
  acwa_pkg::entry_t wdata, rdata;
  logic [IW-1:0]    raddr;

  acwa_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // per-slot compare on the data coming out of the store
  logic       slot_ok, uid_m, sa_m;
  logic [7:0] lim;
  logic [8:0] age_nx;
  logic       expire;

  always_comb begin
    slot_ok = rd_pend_q && valid_q[rd_idx_q];
    uid_m = rdata.unique_id == req_q.node_unique_id;
    sa_m = (rdata.nwk_addr == req_q.node_short_addr) &&
           (rdata.net_id == req_q.node_net_id);
    case (rdata.media)
      2'd0: lim = wifi_q;
      2'd1: lim = ble_q;
      2'd2: lim = lowpan_q;
      default: lim = 8'd0;
    endcase
    age_nx = {1'b0, rdata.age} + 9'd1;
    expire = age_nx > {1'b0, lim};
  end

  logic scan_end;
  assign scan_end = ptr_q == (IW+1)'(acwa_pkg::Depth);
  logic out_free;
  assign out_free = !out_vld_q || rsp.ready;

  assign req.ready = (state_q == acwa_pkg::FSM_IDLE);
  assign rsp.valid = out_vld_q;
  assign rsp.data = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      acwa_pkg::FSM_IDLE: if (req.valid) state_d = acwa_pkg::FSM_SCAN;
      acwa_pkg::FSM_SCAN: begin
        if (req_q.mode == acwa_pkg::MODE_TICK && report_q) begin
          if (scan_end && !rd_pend_q) state_d = acwa_pkg::FSM_OUT;
        end else if (scan_end && !rd_pend_q) begin
          if (req_q.mode == acwa_pkg::MODE_TICK) state_d = acwa_pkg::FSM_SCAN;
          else if (req_q.mode == acwa_pkg::MODE_UPDATE) state_d = acwa_pkg::FSM_WRITE;
          else state_d = acwa_pkg::FSM_RESULT;
        end
      end
      acwa_pkg::FSM_WRITE:  state_d = acwa_pkg::FSM_RESULT;
      acwa_pkg::FSM_RESULT: if (out_free) state_d = acwa_pkg::FSM_IDLE;
      acwa_pkg::FSM_OUT:    if (out_free) state_d = acwa_pkg::FSM_IDLE;
      default: state_d = acwa_pkg::FSM_IDLE;
    endcase
  end

  // store write: tick ages in place during the first pass, update in FSM_WRITE
  always_comb begin
    we = 1'b0;
    waddr = rd_idx_q;
    wdata = rdata;
    if (state_q == acwa_pkg::FSM_SCAN && req_q.mode == acwa_pkg::MODE_TICK &&
        !report_q && slot_ok && !expire) begin
      we = 1'b1;
      wdata.age = age_nx[7:0];
    end
    if (state_q == acwa_pkg::FSM_WRITE && (hit_q || free_q)) begin
      we = 1'b1;
      waddr = hit_q ? hit_idx_q : free_idx_q;
      wdata.unique_id = req_q.node_unique_id;
      wdata.nwk_addr = req_q.node_short_addr;
      wdata.net_id = req_q.node_net_id;
      wdata.parent_addr = req_q.parent_short_addr;
      wdata.media = req_q.media_kind;
      wdata.age = 8'd0;
    end
  end

  // in the report pass the scan stalls on each eviction until the output is free
  logic rep_emit, rep_stall;
  assign rep_emit = state_q == acwa_pkg::FSM_SCAN && req_q.mode == acwa_pkg::MODE_TICK &&
                    report_q && rd_pend_q && evict_q[rd_idx_q];
  assign rep_stall = rep_emit && !out_free;

  // a stalled report re-reads the held slot so its data stays on rdata
  assign raddr = rep_stall ? rd_idx_q : ptr_q[IW-1:0];

  // output register loads a new result
  logic out_set;
  assign out_set = (rep_emit && out_free) ||
                   ((state_q == acwa_pkg::FSM_RESULT || state_q == acwa_pkg::FSM_OUT) &&
                    out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acwa_pkg::FSM_IDLE;
      valid_q <= '0;
      evict_q <= '0;
      count_q <= '0;
      ptr_q <= '0;
      rd_pend_q <= 1'b0;
      rd_idx_q <= '0;
      hit_q <= 1'b0;
      hit_idx_q <= '0;
      free_q <= 1'b0;
      free_idx_q <= '0;
      report_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_set) out_vld_q <= 1'b1;
      else if (rsp.ready) out_vld_q <= 1'b0;
      case (state_q)
        acwa_pkg::FSM_IDLE: if (req.valid) begin
          ptr_q <= '0;
          rd_pend_q <= 1'b0;
          hit_q <= 1'b0;
          free_q <= 1'b0;
          report_q <= 1'b0;
          evict_q <= '0;
        end
        acwa_pkg::FSM_SCAN: if (!rep_stall) begin
          if (!scan_end) ptr_q <= ptr_q + (IW+1)'(1);
          rd_pend_q <= !scan_end;
          rd_idx_q <= ptr_q[IW-1:0];
          if (rd_pend_q) begin
            if (!valid_q[rd_idx_q] && !free_q) begin
              free_q <= 1'b1;
              free_idx_q <= rd_idx_q;
            end
            if (slot_ok && !hit_q &&
                ((req_q.mode == acwa_pkg::MODE_LOOKUP_SA) ? sa_m : uid_m)) begin
              hit_q <= 1'b1;
              hit_idx_q <= rd_idx_q;
              hit_ent_q <= rdata;
            end
            if (req_q.mode == acwa_pkg::MODE_TICK && !report_q && slot_ok && expire) begin
              evict_q[rd_idx_q] <= 1'b1;
              valid_q[rd_idx_q] <= 1'b0;
              count_q <= count_q - CW'(1);
            end
          end
          if (rep_emit) begin
            out_q <= '{acwa_pkg::ST_EVICTED, rdata.unique_id, rdata.nwk_addr,
                       rdata.net_id, rdata.parent_addr, rdata.media, count_q, 1'b0};
          end
          if (req_q.mode == acwa_pkg::MODE_TICK && !report_q && scan_end && !rd_pend_q) begin
            report_q <= 1'b1;
            ptr_q <= '0;
          end
        end
        acwa_pkg::FSM_WRITE: begin
          if (!hit_q && free_q) begin
            valid_q[free_idx_q] <= 1'b1;
            count_q <= count_q + CW'(1);
            hit_q <= 1'b1;
            hit_idx_q <= free_idx_q;
            hit_ent_q.unique_id <= req_q.node_unique_id;
          end
          hit_ent_q.nwk_addr <= req_q.node_short_addr;
          hit_ent_q.net_id <= req_q.node_net_id;
          hit_ent_q.parent_addr <= req_q.parent_short_addr;
          hit_ent_q.media <= req_q.media_kind;
          if (!hit_q && !free_q) hit_ent_q.unique_id <= req_q.node_unique_id;
        end
        acwa_pkg::FSM_RESULT: if (out_free) begin
          if (req_q.mode == acwa_pkg::MODE_LOOKUP_UID &&
              req_q.node_unique_id == luid_q) begin
            out_q <= '{acwa_pkg::ST_OK, luid_q, lsa_q, lnid_q, 16'hFFFF, 2'd0,
                       count_q, 1'b1};
          end else if (hit_q) begin
            out_q <= '{acwa_pkg::ST_OK, hit_ent_q.unique_id, hit_ent_q.nwk_addr,
                       hit_ent_q.net_id, hit_ent_q.parent_addr, hit_ent_q.media,
                       count_q, 1'b1};
          end else if (req_q.mode == acwa_pkg::MODE_UPDATE) begin
            out_q <= '{acwa_pkg::ST_FULL, hit_ent_q.unique_id, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 2'd0, count_q, 1'b1};
          end else begin
            out_q <= '{acwa_pkg::ST_NOT_FOUND, 64'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       2'd0, count_q, 1'b1};
          end
        end
        acwa_pkg::FSM_OUT: if (out_free) begin
          out_q <= '{acwa_pkg::ST_TICK_DONE, 64'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     2'd0, count_q, 1'b1};
        end
        default: ;
      endcase
    end
  end

  // request register, taken at the transfer
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) req_q <= req.data;
  end

`ifndef SYNTH
  // entry count tracks the valid bits
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CW'($countones(valid_q)))
    else $error("entry count differs from valid bits");
  // no input taken while a scan runs
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == acwa_pkg::FSM_SCAN |-> !req.ready)
    else $error("ready during scan");
  // a pending result is never overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result lost under stall");
`endif
endmodule

// ===== design/acwa_ram.sv =====
// acwa_ram: entry store, one write and one registered read port
// depends on acwa_pkg
module acwa_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [acwa_pkg::IdxW-1:0] waddr_i,
  input  acwa_pkg::entry_t         wdata_i,
  input  logic [acwa_pkg::IdxW-1:0] raddr_i,
  output acwa_pkg::entry_t         rdata_o
);
  acwa_pkg::entry_t mem_q [acwa_pkg::Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
